// ===== design/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque: operation kinds, result
// status codes, controller states and the controller/datapath command and
// status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

    // operation kinds carried in one input word
    localparam logic [2:0] KIND_CREATE     = 3'd0;
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd2;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
    localparam logic [2:0] KIND_POP_BACK   = 3'd4;
    localparam logic [2:0] KIND_DUMP       = 3'd5;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;    // latch the input word
        logic execute;    // apply the operation to the queue
        logic load_read;  // move read data into the result register
        logic dump_next;  // step the dump to the next entry
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic kind_valid; // kind is a defined operation
        logic needs_read; // operation returns a stored entry
        logic more_dump;  // dump has entries left after the current word
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/bounded_deque_top.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_top
// Double-ended queue of signed 32-bit words in a ring buffer of DEPTH
// entries, with clear-and-create, push and pop at both ends, and dump.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one operation word (i_kind,
//   i_value); output channel o_valid/i_ready carries result words
//   (o_status, o_result_value, o_last), o_last marking the final word of
//   an operation.
//   One operation is in flight at a time; o_ready is high only while idle.
//   Create and push: the word is captured and executed, then its result shown.
//   Pop: captured and executed, then the entry read (registered memory read)
//   is loaded into the result. Pop or dump of an empty queue answers like a push.
//   Dump: one word per stored entry, each read through the single read port
//   of the entry memory and the registered result stage.
//   Kinds 6 and 7 are dropped with no result.
//   Reset empties the queue at once; there is no clearing pass, entries are
//   only read after being written.
//   A stalled receiver holds the result word in place and the block takes
//   no new operation until the final word of the current one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_top import bdq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_kind,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_result_value,
    output logic                    o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencing
    bdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // storage and result path
    bdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_kind         (i_kind),
        .i_value        (i_value),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// ===== design/bdq_dp.sv =====
// ----------------------------------------------------------------------------
// bdq_dp
// Datapath of the bounded deque: ring buffer storage, front index, entry
// count, dump cursor and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_dp import bdq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_stat                o_stat,
    input  wire logic [2:0]         i_kind,
    input  wire logic signed [31:0] i_value,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_result_value,
    output logic                    o_last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);
    localparam logic [IW-1:0] IDX_MAX    = IW'(DEPTH - 1);

    // index arithmetic modulo the depth; the sum stays below twice the depth
    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    logic signed [31:0] r_mem [DEPTH];

    logic [2:0]         r_kind;
    logic signed [31:0] r_value_in;
    logic [IW-1:0]      r_front, n_front;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_dump_cnt, n_dump_cnt;
    logic [IW-1:0]      r_rd_ptr, n_rd_ptr;
    logic signed [31:0] r_rd_data;
    logic [1:0]         r_res_status, n_res_status;
    logic signed [31:0] r_res_value, n_res_value;
    logic               r_res_last, n_res_last;

    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic               rd_en;
    logic               q_empty;
    logic               q_full;
    logic [IW-1:0]      front_dec;
    logic [IW-1:0]      front_inc;
    logic [IW-1:0]      ptr_inc;
    logic [IW-1:0]      back_wr;
    logic [IW-1:0]      back_rd;
    logic [CW-1:0]      dump_seen;

    // queue occupancy and neighbor indexes
    assign q_empty   = (r_count == '0);
    assign q_full    = (r_count == COUNT_FULL);
    assign front_dec = (r_front == '0) ? IDX_MAX : r_front - 1'b1;
    assign front_inc = (r_front == IDX_MAX) ? '0 : r_front + 1'b1;
    assign ptr_inc   = (r_rd_ptr == IDX_MAX) ? '0 : r_rd_ptr + 1'b1;
    assign back_wr   = wrap_add(r_front, r_count);
    assign back_rd   = wrap_add(r_front, r_count - 1'b1);
    assign dump_seen = r_dump_cnt + 1'b1;

    // status toward the controller
    assign o_stat.kind_valid = (r_kind <= KIND_DUMP);
    assign o_stat.needs_read = (r_kind inside {KIND_POP_FRONT, KIND_POP_BACK, KIND_DUMP})
                               && !q_empty;
    assign o_stat.more_dump  = (r_kind == KIND_DUMP) && (r_res_status == STATUS_OK)
                               && !r_res_last;

    // operation decode and next values
    always_comb begin
        n_front      = r_front;
        n_count      = r_count;
        n_dump_cnt   = r_dump_cnt;
        n_rd_ptr     = r_rd_ptr;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_res_last   = r_res_last;
        wr_en        = 1'b0;
        wr_addr      = r_front;
        rd_en        = 1'b0;

        if (i_cmd.execute) begin
            n_res_status = STATUS_OK;
            n_res_value  = '0;
            n_res_last   = 1'b1;
            case (r_kind)
                KIND_CREATE: begin
                    n_front = '0;
                    n_count = CW'(1);
                    wr_en   = 1'b1;
                    wr_addr = '0;
                end
                KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                    if (q_full) begin
                        n_res_status = STATUS_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + 1'b1;
                        if (r_kind == KIND_PUSH_FRONT) begin
                            n_front = front_dec;
                            wr_addr = front_dec;
                        end else begin
                            wr_addr = back_wr;
                        end
                    end
                end
                KIND_POP_FRONT, KIND_POP_BACK: begin
                    if (q_empty) begin
                        n_res_status = STATUS_EMPTY;
                    end else begin
                        rd_en   = 1'b1;
                        n_count = r_count - 1'b1;
                        if (r_kind == KIND_POP_FRONT) begin
                            n_rd_ptr = r_front;
                            n_front  = front_inc;
                        end else begin
                            n_rd_ptr = back_rd;
                        end
                    end
                end
                KIND_DUMP: begin
                    if (q_empty) begin
                        n_res_status = STATUS_EMPTY;
                    end else begin
                        rd_en      = 1'b1;
                        n_rd_ptr   = r_front;
                        n_dump_cnt = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        // entry read back: pops give one word, dumps mark the final entry
        if (i_cmd.load_read) begin
            n_res_status = STATUS_OK;
            n_res_value  = r_rd_data;
            n_res_last   = (r_kind == KIND_DUMP) ? (dump_seen == r_count) : 1'b1;
        end

        // next dump entry
        if (i_cmd.dump_next) begin
            n_dump_cnt = dump_seen;
            n_rd_ptr   = ptr_inc;
            rd_en      = 1'b1;
        end
    end

    // ring buffer storage with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_value_in;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[n_rd_ptr];
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_count    <= '0;
            r_kind     <= KIND_CREATE;
            r_dump_cnt <= '0;
            r_rd_ptr   <= '0;
        end else begin
            r_front    <= n_front;
            r_count    <= n_count;
            r_dump_cnt <= n_dump_cnt;
            r_rd_ptr   <= n_rd_ptr;
            if (i_cmd.capture) begin
                r_kind <= i_kind;
            end
        end
    end

    // input value and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_value_in <= i_value;
        end
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_res_last   <= n_res_last;
    end

    assign o_status       = r_res_status;
    assign o_result_value = r_res_value;
    assign o_last         = r_res_last;

endmodule

`default_nettype wire

// ===== design/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Controller of the bounded deque: sequences capture, execution, entry
// read and result handshake for one input word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl import bdq_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  wire logic     i_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_stat.kind_valid) begin
                    n_state = ST_IDLE;
                end else if (i_stat.needs_read) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_READ: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state = i_stat.more_dump ? ST_READ : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_valid;
            end
            ST_EXEC: begin
                o_cmd.execute = 1'b1;
            end
            ST_READ: begin
                o_cmd.load_read = 1'b1;
            end
            ST_OUT: begin
                o_valid         = 1'b1;
                o_cmd.dump_next = i_ready && i_stat.more_dump;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/bdq_chk.sv =====
// ----------------------------------------------------------------------------
// bdq_chk
// Port-level checks for the bounded deque, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_chk import bdq_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic [1:0]         o_status,
    input wire logic signed [31:0] o_result_value,
    input wire logic               o_last
);

    // an offered operation word stays up until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid)
        else $error("operation word withdrawn before it was taken");

    // a stalled result word stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_result_value) && $stable(o_status)
                                && $stable(o_last))
        else $error("result word changed while stalled");

    // one operation at a time: no new word taken while a result is shown
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input taken while a result is pending");

    // empty and full reports are single zero-valued final words
    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STATUS_EMPTY || o_status == STATUS_FULL)
        |-> o_last && (o_result_value == '0))
        else $error("error status word not final or not zero");

endmodule

bind bounded_deque_top bdq_chk u_bdq_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_result_value (o_result_value),
    .o_last         (o_last)
);

`default_nettype wire
